// ===== hw/rtl/mic_pkg.sv =====
`default_nettype none

package mic_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned AXIS_W   = 16;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned CAL_W    = 16;
  localparam int unsigned DIFF_W   = AXIS_W + 1;
  localparam int unsigned PROD_W   = DIFF_W + COEF_W;
  localparam int unsigned ACC_W    = PROD_W + 3;
  localparam int unsigned PERIOD_W = 8;
  localparam int unsigned OFFSET_W = 3 * AXIS_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = OFFSET_W;

  localparam int CAL_MAX = 32767;
  localparam int CAL_MIN = -32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_PERIOD = 3'd0,
    REG_COEF_XX       = 3'd1,
    REG_COEF_XY       = 3'd2,
    REG_COEF_XZ       = 3'd3,
    REG_COEF_YY       = 3'd4,
    REG_COEF_YZ       = 3'd5,
    REG_COEF_ZZ       = 3'd6,
    REG_OFFSET_XYZ    = 3'd7
  } cfg_reg_e;

  localparam logic [PERIOD_W-1:0] RST_SAMPLE_PERIOD = 8'd8;
  localparam logic [COEF_W-1:0]   RST_COEF_XX       = 16'd15338;
  localparam logic [COEF_W-1:0]   RST_COEF_XY       = 16'd44;
  localparam logic [COEF_W-1:0]   RST_COEF_XZ       = 16'd425;
  localparam logic [COEF_W-1:0]   RST_COEF_YY       = 16'd15625;
  localparam logic [COEF_W-1:0]   RST_COEF_YZ       = 16'd59;
  localparam logic [COEF_W-1:0]   RST_COEF_ZZ       = 16'd18364;
  localparam logic [OFFSET_W-1:0] RST_OFFSET_XYZ    = 48'd322114486259;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [CAL_W-1:0]  cal_t;

  typedef struct packed {
    logic [BYTE_W-1:0] x_high;
    logic [BYTE_W-1:0] x_low;
    logic [BYTE_W-1:0] z_high;
    logic [BYTE_W-1:0] z_low;
    logic [BYTE_W-1:0] y_high;
    logic [BYTE_W-1:0] y_low;
  } in_word_t;

  typedef struct packed {
    cal_t cal_x;
    cal_t cal_y;
    cal_t cal_z;
    logic clipped;
  } out_word_t;

  typedef struct packed {
    logic prod;
    logic sum;
  } lane_en_t;

  typedef struct packed {
    cal_t value;
    logic clip;
  } lane_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/magnetometer_iron_calibration.sv =====
// Magnetometer hard-iron and soft-iron calibration with decimation.
// The input channel (in_valid, in_stall, in_word) takes one word per tick
// holding the six sensor data bytes. A tick counter lets one word in every
// sample_period through; the others only advance the counter and give no
// result. A passing word is unpacked, the hard-iron offsets are subtracted,
// and three lanes each form one row of the soft-iron matrix product,
// rounded and saturated. A merge stage collects the lanes into out_word
// with a clipped flag, on the out_valid, out_stall channel.
// Words pass the difference, product, sum and merge registers to out_valid.
// One word is taken per cycle while in_stall is low; the rate is set by the
// pipelined 17 by 16 bit multipliers of each lane, one product per lane and
// axis each cycle. Each stage holds its word while the next cannot take it,
// so the input keeps flowing while a result waits; in_stall rises only when
// the whole pipeline is full behind a stalled output. Configuration through
// cfg_wr_en, cfg_index and cfg_data is to be written only while idle; the
// block does not enforce this. Synchronous reset restores the default
// period, matrix and offsets, clears the tick counter, empties the pipeline.
`default_nettype none

module magnetometer_iron_calibration import mic_pkg::*; #(
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_word_t              in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_word_t                  out_word,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [PERIOD_W-1:0] sample_period_r;
  coef_t               coef_xx_r, coef_xy_r, coef_xz_r;
  coef_t               coef_yy_r, coef_yz_r, coef_zz_r;
  logic [OFFSET_W-1:0] offset_xyz_r;

  logic [PERIOD_W-1:0] tick_count_r;
  logic [PERIOD_W-1:0] tick_count_nxt;
  logic [PERIOD_W:0]   tick_inc;
  logic                fire;
  logic                in_take;

  logic signed [AXIS_W-1:0] raw_x, raw_y, raw_z;
  logic signed [AXIS_W-1:0] off_x, off_y, off_z;
  diff_t               dx_nxt, dy_nxt, dz_nxt;
  diff_t               dx_r, dy_r, dz_r;

  logic                v1_r, v2_r, v3_r;
  logic                rdy1, rdy2, rdy3, rdy4;
  lane_en_t            lane_en;
  lane_res_t           res_x, res_y, res_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r <= RST_SAMPLE_PERIOD;
      coef_xx_r       <= RST_COEF_XX;
      coef_xy_r       <= RST_COEF_XY;
      coef_xz_r       <= RST_COEF_XZ;
      coef_yy_r       <= RST_COEF_YY;
      coef_yz_r       <= RST_COEF_YZ;
      coef_zz_r       <= RST_COEF_ZZ;
      offset_xyz_r    <= RST_OFFSET_XYZ;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_SAMPLE_PERIOD: sample_period_r <= cfg_data[PERIOD_W-1:0];
        REG_COEF_XX:       coef_xx_r       <= cfg_data[COEF_W-1:0];
        REG_COEF_XY:       coef_xy_r       <= cfg_data[COEF_W-1:0];
        REG_COEF_XZ:       coef_xz_r       <= cfg_data[COEF_W-1:0];
        REG_COEF_YY:       coef_yy_r       <= cfg_data[COEF_W-1:0];
        REG_COEF_YZ:       coef_yz_r       <= cfg_data[COEF_W-1:0];
        REG_COEF_ZZ:       coef_zz_r       <= cfg_data[COEF_W-1:0];
        REG_OFFSET_XYZ:    offset_xyz_r    <= cfg_data[OFFSET_W-1:0];
        default:           sample_period_r <= sample_period_r;
      endcase
    end
  end

  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign in_take  = in_valid && rdy1;

  assign tick_inc       = (PERIOD_W + 1)'(tick_count_r) + (PERIOD_W + 1)'(1);
  assign fire           = tick_inc >= (PERIOD_W + 1)'(sample_period_r);
  assign tick_count_nxt = fire ? '0 : tick_inc[PERIOD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
    end else if (in_take) begin
      tick_count_r <= tick_count_nxt;
    end
  end

  assign raw_x  = {in_word.x_high, in_word.x_low};
  assign raw_y  = {in_word.y_high, in_word.y_low};
  assign raw_z  = {in_word.z_high, in_word.z_low};
  assign off_x  = offset_xyz_r[AXIS_W-1:0];
  assign off_y  = offset_xyz_r[2*AXIS_W-1:AXIS_W];
  assign off_z  = offset_xyz_r[3*AXIS_W-1:2*AXIS_W];
  assign dx_nxt = DIFF_W'(raw_x) - DIFF_W'(off_x);
  assign dy_nxt = DIFF_W'(raw_y) - DIFF_W'(off_y);
  assign dz_nxt = DIFF_W'(raw_z) - DIFF_W'(off_z);

  always_ff @(posedge clk) begin
    if (in_take && fire) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      dz_r <= dz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid && fire;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  assign lane_en.prod = v1_r && rdy2;
  assign lane_en.sum  = v2_r && rdy3;

  mic_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_x (
    .clk (clk),
    .en  (lane_en),
    .d_x (dx_r),
    .d_y (dy_r),
    .d_z (dz_r),
    .k_x (coef_xx_r),
    .k_y (coef_xy_r),
    .k_z (coef_xz_r),
    .res (res_x)
  );

  mic_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_y (
    .clk (clk),
    .en  (lane_en),
    .d_x (dx_r),
    .d_y (dy_r),
    .d_z (dz_r),
    .k_x (coef_xy_r),
    .k_y (coef_yy_r),
    .k_z (coef_yz_r),
    .res (res_y)
  );

  mic_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_z (
    .clk (clk),
    .en  (lane_en),
    .d_x (dx_r),
    .d_y (dy_r),
    .d_z (dz_r),
    .k_x (coef_xz_r),
    .k_y (coef_yz_r),
    .k_z (coef_zz_r),
    .res (res_z)
  );

  mic_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (v3_r),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_z     (res_z),
    .res_ready (rdy4),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

`ifndef ASSERT_OFF
  a_tick_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    tick_count_r != {PERIOD_W{1'b1}})
    else $error("tick counter reached its maximum");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && out_valid))
    else $error("input stalled with room in the pipeline");

  a_fire_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && fire) |=> v1_r)
    else $error("passing word did not enter the pipeline");

  a_clip_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.clipped) |->
      (out_word.cal_x == cal_t'(CAL_MAX) || out_word.cal_x == cal_t'(CAL_MIN) ||
       out_word.cal_y == cal_t'(CAL_MAX) || out_word.cal_y == cal_t'(CAL_MIN) ||
       out_word.cal_z == cal_t'(CAL_MAX) || out_word.cal_z == cal_t'(CAL_MIN)))
    else $error("clipped flag without a saturated axis");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mic_lane.sv =====
`default_nettype none

module mic_lane import mic_pkg::*; #(
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  wire logic      clk,
  input  wire lane_en_t  en,
  input  wire diff_t     d_x,
  input  wire diff_t     d_y,
  input  wire diff_t     d_z,
  input  wire coef_t     k_x,
  input  wire coef_t     k_y,
  input  wire coef_t     k_z,
  output lane_res_t      res
);

  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1 << (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(CAL_MAX);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(CAL_MIN);

  prod_t                    prod_x_r, prod_y_r, prod_z_r;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd;
  lane_res_t                res_nxt;
  lane_res_t                res_r;

  always_ff @(posedge clk) begin
    if (en.prod) begin
      prod_x_r <= PROD_W'(d_x) * PROD_W'(k_x);
      prod_y_r <= PROD_W'(d_y) * PROD_W'(k_y);
      prod_z_r <= PROD_W'(d_z) * PROD_W'(k_z);
    end
  end

  // Round to nearest with ties upward, then clamp to the 16-bit range.
  always_comb begin
    acc = ACC_W'(prod_x_r) + ACC_W'(prod_y_r) + ACC_W'(prod_z_r) + HALF;
    rnd = acc >>> COEF_FRAC_BITS;
    if (rnd > SAT_MAX) begin
      res_nxt.value = cal_t'(CAL_MAX);
      res_nxt.clip  = 1'b1;
    end else if (rnd < SAT_MIN) begin
      res_nxt.value = cal_t'(CAL_MIN);
      res_nxt.clip  = 1'b1;
    end else begin
      res_nxt.value = rnd[CAL_W-1:0];
      res_nxt.clip  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mic_merge.sv =====
`default_nettype none

module mic_merge import mic_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      res_valid,
  input  wire lane_res_t res_x,
  input  wire lane_res_t res_y,
  input  wire lane_res_t res_z,
  output logic           res_ready,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  logic      out_valid_r;
  out_word_t out_word_r;

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_word_r.cal_x   <= res_x.value;
      out_word_r.cal_y   <= res_y.value;
      out_word_r.cal_z   <= res_z.value;
      out_word_r.clipped <= res_x.clip | res_y.clip | res_z.clip;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire
